/* src/owe_pkg.sv */
package owe_pkg;
   localparam int STORE_DEPTH = 128;
   localparam int RAM_DEPTH   = 16;
   localparam int SCRATCH_LEN = 13;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int RAM_AW      = $clog2(RAM_DEPTH);

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;

   localparam logic [7:0] CMD_READ_MEM  = 8'hF0;
   localparam logic [7:0] CMD_READ_SP   = 8'hAA;
   localparam logic [7:0] CMD_COPY      = 8'h55;
   localparam logic [7:0] CMD_WRITE_SP  = 8'h0F;
   localparam logic [7:0] ES_VALUE      = 8'h01;
   localparam logic [15:0] CRC_PARITY_XOR = 16'hC001;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_valid;
      logic       copy_failed;
      logic       scratch_written;
   } rsp_type;

   // one byte of the reflected CRC-16, parity form
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
      logic [15:0] c;
      logic [15:0] r;
      c = {8'd0, d ^ crc[7:0]};
      r = {8'd0, crc[15:8]};
      if (^c[7:0]) r = r ^ CRC_PARITY_XOR;
      r = r ^ (c << 6) ^ (c << 7);
      return r;
   endfunction
endpackage

/* src/owe_if.sv */
interface owe_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* src/one_wire_eeprom_slave.sv */
// A bus event is answered after it passes the read and output states; a matching copy
// passes the read state, then writes one byte per cycle into RAM or the store.
// No new event is accepted while a response is pending or the block is busy.
// Reset (synchronous, active high): control idles and the scratchpad clears, then
// store and RAM are cleared by a sweep over the store addresses during which no event is accepted.
module one_wire_eeprom_slave
   import owe_pkg::*;
(
   input logic clock,
   input logic reset,
   owe_if.sink   req,
   owe_if.source rsp
);
   typedef enum logic [3:0] {
      PH_IDLE, PH_RD_LO, PH_RD_HI, PH_RD_STREAM, PH_SP_STREAM,
      PH_CP_TA1, PH_CP_TA2, PH_CP_ES, PH_WS_TA1, PH_WS_TA2, PH_WS_DATA,
      PH_WS_CRC_LO, PH_WS_CRC_HI
   } phase_type;

   typedef enum logic [2:0] {
      SQ_CLEAR, SQ_WAIT, SQ_READ, SQ_COPY, SQ_OUT
   } seq_type;

   logic [7:0] store_mem [STORE_DEPTH];
   logic [7:0] ram_mem [RAM_DEPTH];
   logic [7:0] scratch_ff [16];

   seq_type    seq_ff;
   phase_type  phase_ff;
   logic [7:0] addr_ff;
   logic [3:0] idx_ff;
   logic [15:0] crc_ff;
   logic       written_ff;
   logic [STORE_AW-1:0] clr_ff;
   logic [2:0] cp_ff;
   req_type    item_ff;
   logic [7:0] store_rd_ff;
   logic [7:0] ram_rd_ff;
   logic       zero_rd_ff;
   logic       from_ram_ff;
   rsp_type    rsp_ff;
   logic       rsp_valid_ff;

   // read address into map
   logic [7:0] map_a;
   logic [STORE_AW-1:0] store_ra;
   always_comb begin
      map_a = addr_ff;
      if (map_a < 8'd16) store_ra = map_a[STORE_AW-1:0];
      else if (map_a < 8'd64) store_ra = 7'(map_a - 8'd16);
      else store_ra = 7'(map_a - 8'd128);
   end

   // copy write address and scratchpad source index
   logic [7:0] cp_addr;
   logic [3:0] cp_src;
   assign cp_addr = scratch_ff[0] + {5'd0, cp_ff};
   assign cp_src  = 4'd3 + {1'b0, cp_ff};

   assign req.ready = (seq_ff == SQ_WAIT) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   // memories
   always_ff @(posedge clock) begin
      store_rd_ff <= store_mem[store_ra];
      ram_rd_ff   <= ram_mem[addr_ff[RAM_AW-1:0]];
      if (seq_ff == SQ_CLEAR) begin
         store_mem[clr_ff] <= 8'd0;
         ram_mem[clr_ff[RAM_AW-1:0]] <= 8'd0;
      end else if (seq_ff == SQ_COPY) begin
         if (cp_addr <= 8'd15) ram_mem[cp_addr[RAM_AW-1:0]] <= scratch_ff[cp_src];
         if (cp_addr >= 8'd128) store_mem[cp_addr[STORE_AW-1:0]] <= scratch_ff[cp_src];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SQ_CLEAR; phase_ff <= PH_IDLE; addr_ff <= '0; idx_ff <= '0;
         crc_ff <= '0; written_ff <= 1'b0; clr_ff <= '0; cp_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 16; i++) scratch_ff[i] <= 8'd0;
      end else begin
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         case (seq_ff)
            SQ_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == STORE_AW'(STORE_DEPTH - 1)) seq_ff <= SQ_WAIT;
            end
            SQ_WAIT: begin
               if (req.valid && req.ready) begin
                  item_ff <= req.payload;
                  seq_ff <= SQ_READ;
               end
            end
            SQ_READ: begin
               // registered memory data now valid for addr_ff
               zero_rd_ff <= (addr_ff >= 8'd64) && (addr_ff < 8'd128);
               from_ram_ff <= (addr_ff >= 8'd16) && (addr_ff < 8'd32);
               rsp_ff <= '0;
               if (item_ff.operation == OP_WRITE && phase_ff == PH_CP_ES &&
                   scratch_ff[2] == item_ff.data_byte) begin
                  cp_ff <= '0;
                  seq_ff <= SQ_COPY;
               end else begin
                  seq_ff <= SQ_OUT;
               end
            end
            SQ_COPY: begin
               cp_ff <= cp_ff + 1'b1;
               if (cp_ff == 3'd7) begin
                  phase_ff <= PH_IDLE;
                  rsp_ff <= '{8'd0, 1'b0, 1'b0, written_ff};
                  rsp_valid_ff <= 1'b1;
                  seq_ff <= SQ_WAIT;
               end
            end
            SQ_OUT: begin
               logic [7:0] tx;
               logic txv, fail, wr;
               logic [7:0] b;
               logic [3:0] ni;
               tx = 8'd0; txv = 1'b0; fail = 1'b0; wr = written_ff;
               b = item_ff.data_byte;
               ni = idx_ff + 4'd1;
               if (item_ff.operation[1]) begin
                  phase_ff <= PH_IDLE;
               end else if (item_ff.operation == OP_READ) begin
                  case (phase_ff)
                     PH_RD_STREAM: begin
                        tx = zero_rd_ff ? 8'd0 : (from_ram_ff ? ram_rd_ff : store_rd_ff);
                        txv = 1'b1;
                        addr_ff <= addr_ff + 8'd1;
                     end
                     PH_SP_STREAM: begin
                        tx = scratch_ff[idx_ff]; txv = 1'b1;
                        idx_ff <= ni;
                        if (ni >= 4'(SCRATCH_LEN) || ni == 4'd0) phase_ff <= PH_IDLE;
                     end
                     PH_WS_CRC_LO: begin
                        tx = scratch_ff[11]; txv = 1'b1; phase_ff <= PH_WS_CRC_HI;
                     end
                     PH_WS_CRC_HI: begin
                        tx = scratch_ff[12]; txv = 1'b1; wr = 1'b1;
                        written_ff <= 1'b1; phase_ff <= PH_IDLE;
                     end
                     default: ;
                  endcase
               end else begin
                  case (phase_ff)
                     PH_IDLE: begin
                        if (b == CMD_READ_MEM) phase_ff <= PH_RD_LO;
                        else if (b == CMD_READ_SP) begin
                           idx_ff <= '0; phase_ff <= PH_SP_STREAM;
                        end else if (b == CMD_COPY) phase_ff <= PH_CP_TA1;
                        else if (b == CMD_WRITE_SP) phase_ff <= PH_WS_TA1;
                     end
                     PH_RD_LO: begin addr_ff <= b; phase_ff <= PH_RD_HI; end
                     PH_RD_HI: phase_ff <= PH_RD_STREAM;
                     PH_CP_TA1: begin
                        if (scratch_ff[0] != b) begin fail = 1'b1; phase_ff <= PH_IDLE; end
                        else phase_ff <= PH_CP_TA2;
                     end
                     PH_CP_TA2: begin
                        if (scratch_ff[1] != b) begin fail = 1'b1; phase_ff <= PH_IDLE; end
                        else phase_ff <= PH_CP_ES;
                     end
                     PH_CP_ES: begin
                        // a match went through the copy sweep instead
                        fail = 1'b1; phase_ff <= PH_IDLE;
                     end
                     PH_WS_TA1: begin scratch_ff[0] <= b; phase_ff <= PH_WS_TA2; end
                     PH_WS_TA2: begin
                        scratch_ff[1] <= b; scratch_ff[2] <= ES_VALUE;
                        idx_ff <= '0; crc_ff <= '0; phase_ff <= PH_WS_DATA;
                     end
                     PH_WS_DATA: begin
                        logic [15:0] nc;
                        nc = crc_byte(crc_ff, b);
                        scratch_ff[4'(idx_ff + 4'd3)] <= b;
                        crc_ff <= nc;
                        idx_ff <= ni;
                        if (ni >= 4'd8) begin
                           scratch_ff[11] <= nc[7:0];
                           scratch_ff[12] <= nc[15:8];
                           phase_ff <= PH_WS_CRC_LO;
                        end
                     end
                     default: ;
                  endcase
               end
               rsp_ff <= '{tx, txv, fail, wr};
               rsp_valid_ff <= 1'b1;
               seq_ff <= SQ_WAIT;
            end
            default: seq_ff <= SQ_WAIT;
         endcase
      end
   end
endmodule

/* src/owe_checker.sv */
module owe_checker
   import owe_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);
   // no new transfer while a response waits
   a_one_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken with response pending");
   // a response follows each input transfer, later for a copy sweep
   a_resp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> ##[2:9] rsp_valid) else $error("missing response");
   // released bus drives zero
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.tx_valid) |-> rsp_payload.tx_byte == 8'd0)
      else $error("byte driven on released bus");
   // written flag is sticky
   a_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_payload.scratch_written) |=>
      (!rsp_valid || rsp_payload.scratch_written)) else $error("written flag dropped");
endmodule

bind one_wire_eeprom_slave owe_checker u_owe_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);

/* bench/one_wire_eeprom_slave_tb.sv */
`timescale 1ns / 100ps

module one_wire_eeprom_slave_tb;
   import owe_pkg::*;

   localparam logic [1:0] OP_BUS_RESET = 2'd2;
   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int CYCLE_LIMIT = 600000;

   typedef enum logic [3:0] {
      S_IDLE, S_RD_LO, S_RD_HI, S_RD_STREAM, S_SP_STREAM, S_CP_TA1, S_CP_TA2, S_CP_ES,
      S_WS_TA1, S_WS_TA2, S_WS_DATA, S_WS_CRC_LO, S_WS_CRC_HI
   } slave_phase_type;

   logic clock;
   logic reset;

   owe_if #(.payload_type(req_type)) req_ch (.clock(clock));
   owe_if #(.payload_type(rsp_type)) rsp_ch (.clock(clock));

   one_wire_eeprom_slave dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch.sink),
      .rsp  (rsp_ch.source)
   );

   // predictor state
   slave_phase_type mdl_phase;
   logic [7:0]   mdl_addr;
   logic [3:0]   mdl_index;
   logic [7:0]   mdl_scratch [16];
   logic [7:0]   mdl_ram [RAM_DEPTH];
   logic [7:0]   mdl_store [STORE_DEPTH];
   logic [15:0]  mdl_crc;
   logic         mdl_written;

   rsp_type expected_rsp_q [$];
   int  mismatch_count;
   int  send_idle_pct;
   int  recv_idle_pct;
   int  recv_hold_cycles;
   int  cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // reflected CRC-16 step, one bit at a time (poly 0xA001)
   function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] d);
      logic [15:0] r;
      r = crc ^ {8'd0, d};
      for (int i = 0; i < 8; i++)
         r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
      return r;
   endfunction

   function automatic logic [7:0] memory_map_byte(input logic [7:0] a);
      logic [7:0] v;
      if (a < 16) v = mdl_store[a];
      else if (a < 32) v = mdl_ram[a - 16];
      else if (a < 64) v = mdl_store[a - 16];
      else if (a >= 128) v = mdl_store[a - 128];
      else v = 8'd0;
      return v;
   endfunction

   task automatic reset_slave_model();
      mdl_phase   = S_IDLE;
      mdl_addr    = '0;
      mdl_index   = '0;
      mdl_crc     = '0;
      mdl_written = 1'b0;
      for (int i = 0; i < 16; i++) mdl_scratch[i] = '0;
      for (int i = 0; i < RAM_DEPTH; i++) mdl_ram[i] = '0;
      for (int i = 0; i < STORE_DEPTH; i++) mdl_store[i] = '0;
   endtask

   // advance the slave model by one bus event and queue its response
   task automatic predict_bus_event(input req_type ev);
      rsp_type    r;
      logic [7:0] ad;
      r = '0;
      if (ev.operation[1]) begin
         mdl_phase = S_IDLE;
      end else if (ev.operation == OP_READ) begin
         case (mdl_phase)
            S_RD_STREAM: begin
               r.tx_byte = memory_map_byte(mdl_addr);
               r.tx_valid = 1'b1;
               mdl_addr++;
            end
            S_SP_STREAM: begin
               r.tx_byte = mdl_scratch[mdl_index];
               r.tx_valid = 1'b1;
               mdl_index++;
               if (mdl_index >= SCRATCH_LEN || mdl_index == 0) mdl_phase = S_IDLE;
            end
            S_WS_CRC_LO: begin
               r.tx_byte = mdl_scratch[11];
               r.tx_valid = 1'b1;
               mdl_phase = S_WS_CRC_HI;
            end
            S_WS_CRC_HI: begin
               r.tx_byte = mdl_scratch[12];
               r.tx_valid = 1'b1;
               mdl_written = 1'b1;
               mdl_phase = S_IDLE;
            end
            default: ;
         endcase
      end else begin
         case (mdl_phase)
            S_IDLE: begin
               if (ev.data_byte == CMD_READ_MEM) mdl_phase = S_RD_LO;
               else if (ev.data_byte == CMD_READ_SP) begin
                  mdl_index = '0;
                  mdl_phase = S_SP_STREAM;
               end else if (ev.data_byte == CMD_COPY) mdl_phase = S_CP_TA1;
               else if (ev.data_byte == CMD_WRITE_SP) mdl_phase = S_WS_TA1;
            end
            S_RD_LO: begin
               mdl_addr = ev.data_byte;
               mdl_phase = S_RD_HI;
            end
            S_RD_HI: mdl_phase = S_RD_STREAM;
            S_CP_TA1, S_CP_TA2, S_CP_ES: begin
               if (mdl_scratch[mdl_phase - S_CP_TA1] != ev.data_byte) begin
                  r.copy_failed = 1'b1;
                  mdl_phase = S_IDLE;
               end else if (mdl_phase == S_CP_ES) begin
                  for (int i = 0; i < 8; i++) begin
                     ad = mdl_scratch[0] + 8'(i);
                     if (ad <= 15) mdl_ram[ad[3:0]] = mdl_scratch[3 + i];
                     if (ad >= 128) mdl_store[ad[6:0]] = mdl_scratch[3 + i];
                  end
                  mdl_phase = S_IDLE;
               end else begin
                  mdl_phase = slave_phase_type'(mdl_phase + 1);
               end
            end
            S_WS_TA1: begin
               mdl_scratch[0] = ev.data_byte;
               mdl_phase = S_WS_TA2;
            end
            S_WS_TA2: begin
               mdl_scratch[1] = ev.data_byte;
               mdl_scratch[2] = ES_VALUE;
               mdl_index = '0;
               mdl_crc = '0;
               mdl_phase = S_WS_DATA;
            end
            S_WS_DATA: begin
               mdl_scratch[4'(3 + mdl_index)] = ev.data_byte;
               mdl_crc = crc16_update(mdl_crc, ev.data_byte);
               mdl_index++;
               if (mdl_index >= 8) begin
                  mdl_scratch[11] = mdl_crc[7:0];
                  mdl_scratch[12] = mdl_crc[15:8];
                  mdl_phase = S_WS_CRC_LO;
               end
            end
            default: ;
         endcase
      end
      r.scratch_written = mdl_written;
      expected_rsp_q.push_back(r);
   endtask

   // offer one event, hold it until the transfer, predict on acceptance;
   // the block is busy after each transfer, so valid drops between events
   task automatic send_bus_event(input logic [1:0] op, input logic [7:0] d);
      req_type ev;
      ev.operation = op;
      ev.data_byte = d;
      @(posedge clock);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.payload <= ev;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_bus_event(ev);
      req_ch.valid <= 1'b0;
   endtask

   task automatic send_byte(input logic [7:0] d);
      send_bus_event(OP_WRITE, d);
   endtask

   task automatic send_reads(input int n);
      for (int i = 0; i < n; i++) send_bus_event(OP_READ, 8'($urandom));
   endtask

   task automatic wait_all_responses();
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_scratchpad(input logic [7:0] ta1, input logic [7:0] ta2);
      send_bus_event(OP_BUS_RESET, 8'($urandom));
      send_byte(CMD_WRITE_SP);
      send_byte(ta1);
      send_byte(ta2);
      for (int i = 0; i < 8; i++) send_byte(8'($urandom));
      send_reads(2);
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response %h", rsp_ch.payload);
         end else begin
            exp_r = expected_rsp_q.pop_front();
            if (rsp_ch.payload.tx_byte !== exp_r.tx_byte
                || rsp_ch.payload.tx_valid !== exp_r.tx_valid
                || rsp_ch.payload.copy_failed !== exp_r.copy_failed
                || rsp_ch.payload.scratch_written !== exp_r.scratch_written) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected tx=%h v=%b fail=%b sw=%b, got tx=%h v=%b fail=%b sw=%b",
                     exp_r.tx_byte, exp_r.tx_valid, exp_r.copy_failed, exp_r.scratch_written,
                     rsp_ch.payload.tx_byte, rsp_ch.payload.tx_valid,
                     rsp_ch.payload.copy_failed, rsp_ch.payload.scratch_written);
            end
         end
      end
   end

   // receiver ready, with random idling or a long hold-off
   always @(posedge clock) begin
      if (recv_hold_cycles > 0) begin
         recv_hold_cycles <= recv_hold_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic test_directed_commands();
      // write scratchpad with extreme bytes, CRC read, then read it back
      send_bus_event(OP_BUS_RESET, 8'h00);
      send_byte(CMD_WRITE_SP);
      send_byte(8'hF8);
      send_byte(8'h00);
      for (int i = 0; i < 8; i++) send_byte(i[0] ? 8'hFF : 8'h00);
      send_reads(2);
      send_byte(CMD_READ_SP);
      send_reads(14);
      // copy into the top of the store, then a failing copy
      send_byte(CMD_COPY);
      send_byte(8'hF8);
      send_byte(8'h00);
      send_byte(ES_VALUE);
      send_byte(CMD_COPY);
      send_byte(8'hF8);
      send_byte(8'h01);
      // unknown command, stray read, memory read with ignored bytes, unused op code
      send_byte(8'h00);
      send_bus_event(OP_READ, 8'hFF);
      send_byte(CMD_READ_MEM);
      send_byte(8'hFE);
      send_bus_event(OP_READ, 8'h00);
      send_byte(8'hFF);
      send_reads(4);
      send_byte(8'h12);
      send_bus_event(OP_UNUSED, 8'hFF);
   endtask

   task automatic test_aborted_write();
      send_byte(CMD_WRITE_SP);
      send_byte(8'($urandom));
      send_byte(8'($urandom));
      for (int i = 0; i < 3; i++) send_byte(8'($urandom));
      send_bus_event(OP_BUS_RESET, 8'($urandom));
      send_byte(CMD_READ_SP);
      send_reads(13);
   endtask

   // one random transaction: mostly well-formed command sequences
   task automatic random_transaction();
      int kind;
      logic [7:0] a;
      kind = $urandom_range(9);
      case (kind)
         0, 1: begin
            a = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(6) * 8);
            if ($urandom_range(1)) a = 8'h80 + 8'($urandom_range(15) * 8);
            write_scratchpad(a, 8'($urandom));
         end
         2, 3: begin
            send_bus_event(OP_BUS_RESET, 8'($urandom));
            send_byte(CMD_COPY);
            for (int i = 0; i < 3; i++)
               send_byte($urandom_range(7) == 0 ? 8'($urandom) : mdl_scratch[i]);
         end
         4, 5: begin
            send_bus_event(OP_BUS_RESET, 8'($urandom));
            send_byte(CMD_READ_MEM);
            send_byte(8'($urandom));
            send_byte(8'($urandom));
            send_reads($urandom_range(1, 12));
         end
         6: begin
            send_bus_event(OP_BUS_RESET, 8'($urandom));
            send_byte(CMD_READ_SP);
            send_reads($urandom_range(1, 15));
         end
         default: begin
            for (int i = 0; i < 4; i++)
               send_bus_event(2'($urandom_range(3)), 8'($urandom));
         end
      endcase
   endtask

   task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
      int start_q;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      start_q = 0;
      while (start_q < n_items) begin
         random_transaction();
         start_q += 8;
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      recv_hold_cycles <= 300;
      send_byte(CMD_READ_MEM);
      send_byte(8'h0C);
      send_byte(8'h00);
      send_reads(30);
      // sender pause until the block is drained
      wait_all_responses();
      send_reads(4);
   endtask

   initial begin
      req_type idle_ev;
      idle_ev = '0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = idle_ev;
      rsp_ch.ready = 1'b0;
      mismatch_count = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      recv_hold_cycles = 0;
      cycle_count = 0;
      reset_slave_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 15;
      recv_idle_pct = 52;
      test_directed_commands();
      test_aborted_write();
      test_random_traffic(600, 15, 52);
      test_random_traffic(600, 52, 15);
      test_backpressure();
      test_random_traffic(650, 0, 0);

      wait_all_responses();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
